/* hdl/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, idle during reset
`define CHK_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

/* hdl/lzfd_pkg.sv */
// ----------------------------------------------------------------------------
// lzfd_pkg
// Shared constants and types of the flag-word LZ decompressor.
// ----------------------------------------------------------------------------
package lzfd_pkg;
  localparam int WinDepth  = 4096;
  localparam int WinAw     = $clog2(WinDepth);
  localparam int PerRes    = 4;
  localparam int CntW      = 3;

  localparam logic [7:0] MagicF   = 8'h46;
  localparam logic [7:0] MagicA   = 8'h41;
  localparam logic [7:0] MagicB   = 8'h42;
  localparam logic [7:0] TypeByte = 8'h0c;

  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_DONE   = 3'd1,
    ST_MAGIC  = 3'd2,
    ST_TYPE   = 3'd3,
    ST_STREAM = 3'd4,
    ST_FAR    = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]      data_0;
    logic [7:0]      data_1;
    logic [7:0]      data_2;
    logic [7:0]      data_3;
    logic [CntW-1:0] byte_count;
    logic [2:0]      status;
    logic [15:0]     total_length;
    logic            last;
  } result_t;
endpackage

/* hdl/lzfd_if.sv */
// ----------------------------------------------------------------------------
// lzfd_in_if / lzfd_out_if
// Valid/ready channels carrying compressed bytes and result words.
// ----------------------------------------------------------------------------
interface lzfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] compressed_byte;
  modport source (output valid, output compressed_byte, input ready);
  modport sink (input valid, input compressed_byte, output ready);
endinterface

interface lzfd_out_if import lzfd_pkg::*;;
  logic            valid;
  logic            ready;
  logic [7:0]      data_0;
  logic [7:0]      data_1;
  logic [7:0]      data_2;
  logic [7:0]      data_3;
  logic [CntW-1:0] byte_count;
  logic [2:0]      status;
  logic [15:0]     total_length;
  logic            last;
  modport source (output valid, output data_0, output data_1, output data_2,
                  output data_3, output byte_count, output status,
                  output total_length, output last, input ready);
  modport sink (input valid, input data_0, input data_1, input data_2,
                input data_3, input byte_count, input status,
                input total_length, input last, output ready);
endinterface

/* hdl/lz_flagword_decompressor_core.sv */
// ----------------------------------------------------------------------------
// lz_flagword_decompressor_core
// Flag-word LZ decompressor top level.
// ----------------------------------------------------------------------------
// Takes one compressed byte per accepted word. Header and flag-word bytes are
// taken one per cycle while no result word waits to be accepted. After a flag
// word or a token's request the parser walks flag bits, each shifted out and
// then acted on, until it needs the next byte. A literal is sent as one
// request, and the next byte waits until its result word is accepted. A match
// copies through the 4096-byte history RAM byte by byte (registered read, then
// write-back) into result words of up to four bytes; input stalls until the
// last word is accepted. One item is in work at a time. No clearing pass: the
// distance check keeps every read inside bytes already written.
module lz_flagword_decompressor_core import lzfd_pkg::*; (
  input logic        clk,
  input logic        rst,
  lzfd_in_if.sink    in,
  lzfd_out_if.source out
);
  typedef enum logic [3:0] {
    P_F, P_A, P_B, P_TYPE, P_WLO, P_WHI, P_LIT, P_LLO, P_LHI, P_LEXT, P_SOFF,
    P_HALT, P_DEC
  } phase_t;
  typedef enum logic [2:0] {T_FLAG, T_KIND, T_LEN1, T_LEN2, T_INIT} tstep_t;

  phase_t         phase;
  tstep_t         tstep;
  logic [15:0]    flags;
  logic [4:0]     bits_rem;
  logic [7:0]     lo;
  logic [7:0]     hi;
  logic [8:0]     plen;
  logic           have_bit;
  logic           cur_bit;

  logic           req, req_lit, req_stat, busy, far;
  logic [7:0]     req_byte;
  logic [WinAw:0] req_off;
  logic [8:0]     req_len;
  status_t        req_status;

  logic           acc;
  logic [7:0]     b;
  logic [WinAw:0] long_off;

  assign b   = in.compressed_byte;
  assign acc = in.valid && in.ready;
  assign in.ready = !busy && !req && phase != P_DEC;
  assign long_off = (WinAw+1)'(WinDepth) - (WinAw+1)'({hi[7:4], lo});

  lzfd_copy u_copy (
    .clk(clk), .rst(rst), .req(req), .req_lit(req_lit), .req_byte(req_byte),
    .req_off(req_off), .req_len(req_len), .req_stat(req_stat),
    .req_status(req_status), .busy(busy), .far(far), .out(out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= P_F;
      tstep    <= T_INIT;
      flags    <= '0;
      bits_rem <= 5'd16;
      plen     <= '0;
      req      <= 1'b0;
      have_bit <= 1'b0;
    end else if (req) begin
      // copy engine takes the request this cycle; catch far distance here
      if (!req_lit && !req_stat && far) begin
        // keep req up: it now carries the status word
        req_stat   <= 1'b1;
        req_status <= ST_FAR;
        phase      <= P_HALT;
      end else begin
        req <= 1'b0;
        if (!req_stat) begin
          tstep    <= T_FLAG;
          have_bit <= 1'b0;
          phase    <= P_DEC;
        end
      end
    end else if (phase == P_DEC) begin
      // shift out a flag bit, then act on it
      if (!have_bit && bits_rem <= 5'd1) begin
        phase <= P_WLO;
      end else begin
        if (have_bit) begin
          have_bit <= 1'b0;
        end else begin
          cur_bit  <= flags[0];
          flags    <= flags >> 1;
          bits_rem <= bits_rem - 5'd1;
          have_bit <= 1'b1;
        end
        if (have_bit) begin
          case (tstep)
            T_FLAG: if (cur_bit) phase <= P_LIT; else tstep <= T_KIND;
            T_KIND: if (cur_bit) phase <= P_LLO; else tstep <= T_LEN1;
            T_LEN1: begin
              plen  <= {8'd0, cur_bit};
              tstep <= T_LEN2;
            end
            default: begin
              plen  <= {plen[7:0], cur_bit} + 9'd2;
              phase <= P_SOFF;
            end
          endcase
        end
      end
    end else if (acc) begin
      case (phase)
        P_F, P_A, P_B: begin
          if (b != ((phase == P_F) ? MagicF : (phase == P_A) ? MagicA : MagicB)) begin
            req <= 1'b1; req_lit <= 1'b0; req_stat <= 1'b1; req_status <= ST_MAGIC;
            phase <= P_HALT;
          end else begin
            phase <= (phase == P_F) ? P_A : (phase == P_A) ? P_B : P_TYPE;
          end
        end
        P_TYPE: begin
          if (b != TypeByte) begin
            req <= 1'b1; req_lit <= 1'b0; req_stat <= 1'b1; req_status <= ST_TYPE;
            phase <= P_HALT;
          end else begin
            tstep <= T_INIT; phase <= P_WLO;
          end
        end
        P_WLO: begin
          lo <= b; phase <= P_WHI;
        end
        P_WHI: begin
          bits_rem <= 5'd16;
          phase    <= P_DEC;
          if (tstep == T_INIT) begin
            flags <= {b, lo}; tstep <= T_FLAG; have_bit <= 1'b0;
          end else begin
            cur_bit <= flags[0]; flags <= {b, lo}; have_bit <= 1'b1;
          end
        end
        P_LIT: begin
          req <= 1'b1; req_lit <= 1'b1; req_stat <= 1'b0; req_byte <= b;
        end
        P_LLO: begin
          lo <= b; phase <= P_LHI;
        end
        P_LHI: begin
          hi <= b;
          if (b[3:0] != 4'd0) begin
            req      <= 1'b1;
            req_lit  <= 1'b0;
            req_stat <= 1'b0;
            req_off  <= (WinAw+1)'(WinDepth) - (WinAw+1)'({b[7:4], lo});
            req_len  <= {5'd0, b[3:0]} + 9'd2;
          end else begin
            phase <= P_LEXT;
          end
        end
        P_LEXT: begin
          req     <= 1'b1;
          req_lit <= 1'b0;
          if (b == 8'd0) begin
            req_stat <= 1'b1; req_status <= ST_DONE; phase <= P_HALT;
          end else if (b == 8'd1) begin
            req_stat <= 1'b1; req_status <= ST_STREAM; phase <= P_HALT;
          end else begin
            req_stat <= 1'b0; req_off <= long_off; req_len <= {1'b0, b} + 9'd1;
          end
        end
        P_SOFF: begin
          req      <= 1'b1;
          req_lit  <= 1'b0;
          req_stat <= 1'b0;
          req_off  <= (WinAw+1)'(9'd256 - {1'b0, b});
          req_len  <= plen;
        end
        default: phase <= P_HALT;
      endcase
    end
  end
endmodule

/* hdl/lzfd_ram.sv */
// ----------------------------------------------------------------------------
// lzfd_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/lzfd_copy.sv */
// ----------------------------------------------------------------------------
// lzfd_copy
// Output packer and history copy engine: literals and match copies go
// through the history RAM, up to four bytes are gathered per result word.
// ----------------------------------------------------------------------------
module lzfd_copy import lzfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // request from parser
  input  logic              req,
  input  logic              req_lit,
  input  logic [7:0]        req_byte,
  input  logic [WinAw:0]    req_off,
  input  logic [8:0]        req_len,
  input  logic              req_stat,
  input  status_t           req_status,
  output logic              busy,
  output logic              far,
  lzfd_out_if.source        out
);
  typedef enum logic [1:0] {S_IDLE, S_READ, S_WAIT, S_SEND} state_t;
  state_t state;

  logic [WinAw-1:0] wpos;
  logic [15:0]      total;
  logic [WinAw:0]   capped;
  logic [WinAw:0]   off;
  logic [8:0]       len;
  logic [7:0]       buf_b [PerRes];
  logic [CntW-1:0]  n;
  logic             we;
  logic [7:0]       wdata;
  logic [7:0]       rdata;
  logic [WinAw-1:0] raddr;

  lzfd_ram #(.Width(8), .Depth(WinDepth)) u_hist (
    .clk(clk), .we(we), .waddr(wpos), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign raddr = wpos - off[WinAw-1:0];
  // read one byte, write it back next cycle; one copy in flight avoids hazards
  assign we    = (state == S_WAIT) || (state == S_IDLE && req && req_lit);
  assign wdata = (state == S_WAIT) ? rdata : req_byte;
  assign busy  = (state != S_IDLE) || out.valid;
  assign far   = req_off > capped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wpos      <= '0;
      total     <= '0;
      capped    <= '0;
      out.valid <= 1'b0;
      n         <= '0;
    end else begin
      // S_SEND reloads the word itself when the current one leaves
      if (out.valid && out.ready && state != S_SEND) begin
        out.valid <= 1'b0;
      end
      if (we) begin
        wpos  <= wpos + 1'b1;
        total <= total + 16'd1;
        if (capped != (WinAw+1)'(WinDepth)) begin
          capped <= capped + 1'b1;
        end
      end
      case (state)
        S_IDLE: begin
          if (req && !out.valid) begin
            if (req_stat) begin
              out.valid        <= 1'b1;
              out.data_0       <= '0;
              out.data_1       <= '0;
              out.data_2       <= '0;
              out.data_3       <= '0;
              out.byte_count   <= '0;
              out.status       <= req_status;
              out.total_length <= total;
              out.last         <= 1'b1;
            end else if (req_lit) begin
              out.valid        <= 1'b1;
              out.data_0       <= req_byte;
              out.data_1       <= '0;
              out.data_2       <= '0;
              out.data_3       <= '0;
              out.byte_count   <= CntW'(1);
              out.status       <= ST_RUN;
              out.total_length <= total + 16'd1;
              out.last         <= 1'b1;
            end else if (!far) begin
              off   <= req_off;
              len   <= req_len;
              n     <= '0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          buf_b[n[1:0]] <= rdata;
          len <= len - 9'd1;
          if (n == CntW'(PerRes-1) || len == 9'd1) begin
            state <= S_SEND;
          end else begin
            n     <= n + 1'b1;
            state <= S_READ;
          end
        end
        S_SEND: begin
          if (!out.valid || out.ready) begin
            out.valid        <= 1'b1;
            out.data_0       <= buf_b[0];
            out.data_1       <= (n >= CntW'(1)) ? buf_b[1] : 8'd0;
            out.data_2       <= (n >= CntW'(2)) ? buf_b[2] : 8'd0;
            out.data_3       <= (n >= CntW'(3)) ? buf_b[3] : 8'd0;
            out.byte_count   <= n + 1'b1;
            out.status       <= ST_RUN;
            out.total_length <= total;
            out.last         <= (len == 9'd0);
            n                <= '0;
            state            <= (len == 9'd0) ? S_IDLE : S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* hdl/lzfd_checker.sv */
// ----------------------------------------------------------------------------
// lzfd_checker
// Port-level checks on the decompressor result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lzfd_checker import lzfd_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CntW-1:0] byte_count,
  input logic [2:0]      status,
  input logic            last
);
  `CHK_IMPLY(a_cnt_max, clk, rst, out_valid, byte_count <= CntW'(PerRes))
  `CHK_IMPLY(a_err_empty, clk, rst, out_valid && status != ST_RUN, byte_count == '0 && last)
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(byte_count))
endmodule

bind lz_flagword_decompressor_core lzfd_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out.valid), .out_ready(out.ready),
  .byte_count(out.byte_count), .status(out.status), .last(out.last)
);
